### src/dan_pkg.sv
package dan_pkg;

  localparam int INT_DIGITS_DEF  = 8;
  localparam int FRAC_DIGITS_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NEGATIVE  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_DECIMALS  = 3'd3,
    ST_LARGE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_TRAIL
  } phase_t;

endpackage

### src/dan_front.sv
module dan_front #(
  parameter int INT_DIGITS  = dan_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = dan_pkg::FRAC_DIGITS_DEF,
  localparam int ICW   = $clog2(INT_DIGITS + 2),
  localparam int FCW   = $clog2(FRAC_DIGITS + 2),
  localparam int JOB_W = dan_pkg::STATUS_W + ICW + 4 * INT_DIGITS + 4 * FRAC_DIGITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char,
  input  logic             in_has_char,
  input  logic             in_last,
  input  logic             q_full,
  output logic             q_push,
  output logic [JOB_W-1:0] q_data
);

  localparam int SW       = dan_pkg::STATUS_W;
  localparam int INT_BASE = SW + ICW;
  localparam int FRAC_BASE = INT_BASE + 4 * INT_DIGITS;

  dan_pkg::phase_t phase_r, phase_nxt;
  logic            neg_r, neg_nxt;
  logic            bad_r, bad_nxt;
  logic            any_r, any_nxt;
  logic [ICW-1:0]  int_cnt_r, int_cnt_nxt;
  logic [FCW-1:0]  frac_cnt_r, frac_cnt_nxt;
  logic [3:0]      int_dig_r [INT_DIGITS];
  logic [3:0]      int_dig_nxt [INT_DIGITS];
  logic [3:0]      frac_dig_r [FRAC_DIGITS];
  logic [3:0]      frac_dig_nxt [FRAC_DIGITS];

  logic            accept;
  logic            is_space;
  logic            is_digit;
  logic            do_int;
  logic            do_frac;
  dan_pkg::status_t status;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign is_space = (in_char == dan_pkg::CH_SPACE) ||
                    (in_char >= dan_pkg::CH_TAB && in_char <= dan_pkg::CH_CR);
  assign is_digit = (in_char >= dan_pkg::CH_ZERO && in_char <= dan_pkg::CH_NINE);

  always_comb begin
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    bad_nxt      = bad_r;
    any_nxt      = any_r;
    int_cnt_nxt  = int_cnt_r;
    frac_cnt_nxt = frac_cnt_r;
    int_dig_nxt  = int_dig_r;
    frac_dig_nxt = frac_dig_r;
    do_int       = 1'b0;
    do_frac      = 1'b0;
    q_push       = 1'b0;
    q_data       = '0;
    status       = dan_pkg::ST_OK;

    if (accept && in_has_char && !neg_r && !bad_r) begin
      case (phase_r)
        dan_pkg::PH_LEAD: begin
          if (is_space) begin
            phase_nxt = dan_pkg::PH_LEAD;
          end else if (in_char == dan_pkg::CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (in_char == dan_pkg::CH_PLUS) begin
            phase_nxt = dan_pkg::PH_INT;
          end else if (is_digit) begin
            do_int    = 1'b1;
            phase_nxt = dan_pkg::PH_INT;
          end else if (in_char == dan_pkg::CH_DOT) begin
            phase_nxt = dan_pkg::PH_FRAC;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        dan_pkg::PH_INT: begin
          if (is_digit) begin
            do_int = 1'b1;
          end else if (in_char == dan_pkg::CH_DOT) begin
            phase_nxt = dan_pkg::PH_FRAC;
          end else if (is_space) begin
            phase_nxt = dan_pkg::PH_TRAIL;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        dan_pkg::PH_FRAC: begin
          if (is_digit) begin
            do_frac = 1'b1;
          end else if (is_space) begin
            phase_nxt = dan_pkg::PH_TRAIL;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        default: begin
          if (!is_space) begin
            bad_nxt = 1'b1;
          end
        end
      endcase
    end

    if (do_int) begin
      any_nxt = 1'b1;
      if (!(in_char[3:0] == 4'd0 && int_cnt_r == '0)) begin
        for (int i = 0; i < INT_DIGITS; i++) begin
          if (int_cnt_r == ICW'(i)) begin
            int_dig_nxt[i] = in_char[3:0];
          end
        end
        if (int_cnt_r <= ICW'(INT_DIGITS)) begin
          int_cnt_nxt = int_cnt_r + ICW'(1);
        end
      end
    end

    if (do_frac) begin
      any_nxt = 1'b1;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
        if (frac_cnt_r == FCW'(i)) begin
          frac_dig_nxt[i] = in_char[3:0];
        end
      end
      if (frac_cnt_r <= FCW'(FRAC_DIGITS)) begin
        frac_cnt_nxt = frac_cnt_r + FCW'(1);
      end
    end

    if (neg_nxt) begin
      status = dan_pkg::ST_NEGATIVE;
    end else if (bad_nxt || !any_nxt) begin
      status = dan_pkg::ST_MALFORMED;
    end else if (frac_cnt_nxt > FCW'(FRAC_DIGITS)) begin
      status = dan_pkg::ST_DECIMALS;
    end else if (int_cnt_nxt > ICW'(INT_DIGITS)) begin
      status = dan_pkg::ST_LARGE;
    end

    q_data[SW-1:0]     = status;
    q_data[SW +: ICW]  = int_cnt_nxt;
    for (int i = 0; i < INT_DIGITS; i++) begin
      q_data[INT_BASE + 4 * i +: 4] = int_dig_nxt[i];
    end
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (frac_cnt_nxt > FCW'(i)) begin
        q_data[FRAC_BASE + 4 * i +: 4] = frac_dig_nxt[i];
      end
    end

    if (accept && in_last) begin
      q_push       = 1'b1;
      phase_nxt    = dan_pkg::PH_LEAD;
      neg_nxt      = 1'b0;
      bad_nxt      = 1'b0;
      any_nxt      = 1'b0;
      int_cnt_nxt  = '0;
      frac_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dan_pkg::PH_LEAD;
      neg_r      <= 1'b0;
      bad_r      <= 1'b0;
      any_r      <= 1'b0;
      int_cnt_r  <= '0;
      frac_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      bad_r      <= bad_nxt;
      any_r      <= any_nxt;
      int_cnt_r  <= int_cnt_nxt;
      frac_cnt_r <= frac_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    int_dig_r  <= int_dig_nxt;
    frac_dig_r <= frac_dig_nxt;
  end

endmodule

### src/dan_queue.sv
module dan_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = dan_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_data = entry_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### src/dan_back.sv
module dan_back #(
  parameter int INT_DIGITS  = dan_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = dan_pkg::FRAC_DIGITS_DEF,
  localparam int ICW   = $clog2(INT_DIGITS + 2),
  localparam int JOB_W = dan_pkg::STATUS_W + ICW + 4 * INT_DIGITS + 4 * FRAC_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [JOB_W-1:0]             q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_char_out,
  output logic [dan_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last_out
);

  localparam int SW        = dan_pkg::STATUS_W;
  localparam int INT_BASE  = SW + ICW;
  localparam int FRAC_BASE = INT_BASE + 4 * INT_DIGITS;
  localparam int PW        = $clog2(INT_DIGITS + FRAC_DIGITS + 2);

  logic [PW-1:0]    pos_r, pos_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       char_r, char_nxt;
  dan_pkg::status_t status_r, status_nxt;
  logic             last_r, last_nxt;

  dan_pkg::status_t job_st;
  logic [ICW-1:0]   job_len;
  logic [ICW-1:0]   int_n;
  logic [PW-1:0]    frac_pos;
  logic [3:0]       dig;
  logic             load;

  assign job_st  = dan_pkg::status_t'(q_data[SW-1:0]);
  assign job_len = q_data[SW +: ICW];
  assign int_n   = (job_len == '0) ? ICW'(1) : job_len;
  assign load    = q_valid & (~valid_r | ~out_stall);

  assign out_valid    = valid_r;
  assign out_char_out = char_r;
  assign out_status   = status_r;
  assign out_last_out = last_r;

  always_comb begin
    frac_pos   = pos_r - PW'(int_n) - PW'(1);
    dig        = 4'd0;
    char_nxt   = char_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    pos_nxt    = pos_r;
    q_pop      = 1'b0;
    valid_nxt  = valid_r & out_stall;

    if (load) begin
      valid_nxt  = 1'b1;
      status_nxt = job_st;
      last_nxt   = 1'b0;
      if (job_st != dan_pkg::ST_OK) begin
        char_nxt = dan_pkg::CH_NUL;
        last_nxt = 1'b1;
      end else if (pos_r < PW'(int_n)) begin
        for (int i = 0; i < INT_DIGITS; i++) begin
          if (pos_r == PW'(i)) begin
            dig = q_data[INT_BASE + 4 * i +: 4];
          end
        end
        char_nxt = (job_len == '0) ? dan_pkg::CH_ZERO : {dan_pkg::CH_ZERO[7:4], dig};
      end else if (pos_r == PW'(int_n)) begin
        char_nxt = dan_pkg::CH_DOT;
      end else begin
        for (int i = 0; i < FRAC_DIGITS; i++) begin
          if (frac_pos == PW'(i)) begin
            dig = q_data[FRAC_BASE + 4 * i +: 4];
          end
        end
        char_nxt = {dan_pkg::CH_ZERO[7:4], dig};
        last_nxt = (frac_pos == PW'(FRAC_DIGITS - 1));
      end

      if (last_nxt) begin
        q_pop   = 1'b1;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r   <= char_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

endmodule

### src/decimal_amount_normalizer.sv
// Validates an amount string fed one character per item and returns its canonical
// fixed-point text, or a single error status on the last result. The parser takes
// one character item every cycle while the two-entry string queue between parser
// and emitter is not full; any item is held off while that queue is full. The emitter
// sends one result per cycle unless out_stall holds it: a good string gives
// max(integer digits, 1) + 1 + FRAC_DIGITS characters, an error one, so a string
// shorter than its output burst is paced by the emitter's one-character-per-cycle output register.
module decimal_amount_normalizer #(
  parameter int INT_DIGITS  = dan_pkg::INT_DIGITS_DEF,
  parameter int FRAC_DIGITS = dan_pkg::FRAC_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_char_in,
  input  logic                         in_has_char,
  input  logic                         in_last_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_char_out,
  output logic [dan_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last_out
);

  localparam int ICW   = $clog2(INT_DIGITS + 2);
  localparam int JOB_W = dan_pkg::STATUS_W + ICW + 4 * INT_DIGITS + 4 * FRAC_DIGITS;

  logic             q_full;
  logic             q_push;
  logic [JOB_W-1:0] q_wr_data;
  logic             q_valid;
  logic             q_pop;
  logic [JOB_W-1:0] q_rd_data;

  dan_front #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char_in),
    .in_has_char (in_has_char),
    .in_last     (in_last_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  dan_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_data (q_rd_data)
  );

  dan_back #(
    .INT_DIGITS  (INT_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_status   (out_status),
    .out_last_out (out_last_out)
  );

endmodule
